// File: src/stereo_frame_pair_selector_macros.svh
// assertion macros shared by the frame pair selector
`ifndef STEREO_FRAME_PAIR_SELECTOR_MACROS_SVH
`define STEREO_FRAME_PAIR_SELECTOR_MACROS_SVH

// same-cycle implication, off during reset
`define SFPS_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("frame pair selector check failed");

// next-cycle implication, off during reset
`define SFPS_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("frame pair selector check failed");

`endif

// File: src/sfps_pkg.sv
// types and constants of the frame pair selector
package sfps_pkg;

  localparam int unsigned ID_W       = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [TIME_W-1:0] MAX_SKEW_RESET = 48'd8000000;
  localparam logic [TIME_W-1:0] MAX_HOLD_RESET = 48'd18000000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PAIRING_MODE = 2'd0,
    CFG_MAX_SKEW     = 2'd1,
    CFG_MAX_HOLD     = 2'd2
  } cfg_idx_t;

  typedef enum logic [0:0] {
    MODE_HOLD   = 1'b0,
    MODE_LATEST = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t             pairing_mode;
    logic [TIME_W-1:0] max_skew_ns;
    logic [TIME_W-1:0] max_hold_ns;
  } cfg_t;

  typedef struct packed {
    logic              left_present;
    logic [ID_W-1:0]   left_id;
    logic [TIME_W-1:0] left_time;
    logic              right_present;
    logic [ID_W-1:0]   right_id;
    logic [TIME_W-1:0] right_time;
    logic [TIME_W-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic              left_present;
    logic [ID_W-1:0]   left_id;
    logic [TIME_W-1:0] left_time;
    logic              right_present;
    logic [ID_W-1:0]   right_id;
    logic [TIME_W-1:0] right_time;
    logic              promoted;
  } result_t;

  typedef struct packed {
    logic held_valid;
    logic promote;
  } core_status_t;

endpackage

// File: src/sfps_in_if.sv
// input channel: newest frame descriptors and current time
interface sfps_in_if;
  logic                         valid;
  logic                         ready;
  logic                         left_present;
  logic [sfps_pkg::ID_W-1:0]    left_id;
  logic [sfps_pkg::TIME_W-1:0]  left_time;
  logic                         right_present;
  logic [sfps_pkg::ID_W-1:0]    right_id;
  logic [sfps_pkg::TIME_W-1:0]  right_time;
  logic [sfps_pkg::TIME_W-1:0]  now_time;

  modport source (
    output valid, left_present, left_id, left_time,
    output right_present, right_id, right_time, now_time,
    input  ready
  );
  modport sink (
    input  valid, left_present, left_id, left_time,
    input  right_present, right_id, right_time, now_time,
    output ready
  );
endinterface

// File: src/sfps_out_if.sv
// output channel: chosen frame pair
interface sfps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         out_left_present;
  logic [sfps_pkg::ID_W-1:0]    out_left_id;
  logic [sfps_pkg::TIME_W-1:0]  out_left_time;
  logic                         out_right_present;
  logic [sfps_pkg::ID_W-1:0]    out_right_id;
  logic [sfps_pkg::TIME_W-1:0]  out_right_time;
  logic                         promoted;

  modport source (
    output valid, out_left_present, out_left_id, out_left_time,
    output out_right_present, out_right_id, out_right_time, promoted,
    input  ready
  );
  modport sink (
    input  valid, out_left_present, out_left_id, out_left_time,
    input  out_right_present, out_right_id, out_right_time, promoted,
    output ready
  );
endinterface

// File: src/sfps_cfg_if.sv
// configuration write channel
interface sfps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sfps_pkg::CFG_ADDR_W-1:0]  addr;
  logic [sfps_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

// File: src/sfps_pair_core.sv
// held pair state and promotion decision
module sfps_pair_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  sfps_pkg::cfg_t         cfg,
  input  sfps_pkg::item_t        item,
  output sfps_pkg::result_t      result,
  output sfps_pkg::core_status_t status
);

  logic                        held_valid;
  logic                        held_left_present;
  logic [sfps_pkg::ID_W-1:0]   held_left_id;
  logic [sfps_pkg::TIME_W-1:0] held_left_time;
  logic                        held_right_present;
  logic [sfps_pkg::ID_W-1:0]   held_right_id;
  logic [sfps_pkg::TIME_W-1:0] held_right_time;
  logic [sfps_pkg::TIME_W-1:0] last_promote_time;

  logic                        lp;
  logic                        rp;
  logic [sfps_pkg::ID_W-1:0]   lid;
  logic [sfps_pkg::ID_W-1:0]   rid;
  logic [sfps_pkg::TIME_W-1:0] lt;
  logic [sfps_pkg::TIME_W-1:0] rt;
  logic [sfps_pkg::TIME_W-1:0] age;
  logic [sfps_pkg::TIME_W-1:0] skew;
  logic                        left_new;
  logic                        right_new;
  logic                        stale;
  logic                        skew_ok;
  logic                        promote;

  // absent side reads as zero
  always_comb begin
    lp  = item.left_present;
    rp  = item.right_present;
    lid = lp ? item.left_id   : '0;
    lt  = lp ? item.left_time : '0;
    rid = rp ? item.right_id   : '0;
    rt  = rp ? item.right_time : '0;

    left_new  = lp && (!held_left_present || (lid != held_left_id));
    right_new = rp && (!held_right_present || (rid != held_right_id));
    age       = item.now_time - last_promote_time;   // wraps mod 2^48
    stale     = (age >= cfg.max_hold_ns);
    skew      = (lt > rt) ? (lt - rt) : (rt - lt);
    skew_ok   = lp && rp && (skew <= cfg.max_skew_ns);

    promote = (cfg.pairing_mode == sfps_pkg::MODE_HOLD) &&
              (!held_valid || ((left_new || right_new) && (skew_ok || stale)));

    if ((cfg.pairing_mode == sfps_pkg::MODE_LATEST) || promote) begin
      result.left_present  = lp;
      result.left_id       = lid;
      result.left_time     = lt;
      result.right_present = rp;
      result.right_id      = rid;
      result.right_time    = rt;
    end else begin
      result.left_present  = held_left_present;
      result.left_id       = held_left_id;
      result.left_time     = held_left_time;
      result.right_present = held_right_present;
      result.right_id      = held_right_id;
      result.right_time    = held_right_time;
    end
    result.promoted = promote;

    status.held_valid = held_valid;
    status.promote    = promote;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load && promote) begin
      held_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && promote) begin
      held_left_present  <= lp;
      held_left_id       <= lid;
      held_left_time     <= lt;
      held_right_present <= rp;
      held_right_id      <= rid;
      held_right_time    <= rt;
      last_promote_time  <= item.now_time;
    end
  end

endmodule

// File: src/stereo_frame_pair_selector.sv
// stereo frame pair selector: top level with input and result registers
// path: an input transfer passes through the input register and then the result
//   register before its result can be transferred
// throughput: one item per cycle unless stalled; the held pair updates in the
//   same cycle the result register loads, so the next item sees the new pair
// reset: clears pipeline valids and the held pair flag, config goes to
//   hold mode, 8 ms skew limit, 18 ms hold limit
module stereo_frame_pair_selector (
  input  logic       clk,
  input  logic       rst,
  sfps_in_if.sink    frame_in,
  sfps_out_if.source pair_out,
  sfps_cfg_if.sink   cfg
);

  `include "stereo_frame_pair_selector_macros.svh"

  // configuration registers
  sfps_pkg::cfg_t cfg_regs;

  // input register stage
  sfps_pkg::item_t item;
  logic            item_valid;

  // result register stage
  sfps_pkg::result_t res;
  logic              res_valid;

  sfps_pkg::result_t      core_result;
  sfps_pkg::core_status_t core_status;

  logic in_xfer;
  logic res_ready;
  logic item_adv;

  // config port never stalls; the user must write only while idle, the block does not enforce it
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pairing_mode <= sfps_pkg::MODE_HOLD;
      cfg_regs.max_skew_ns  <= sfps_pkg::MAX_SKEW_RESET;
      cfg_regs.max_hold_ns  <= sfps_pkg::MAX_HOLD_RESET;
    end else if (cfg.valid) begin
      // unknown indexes are dropped
      if (cfg.addr == sfps_pkg::CFG_PAIRING_MODE) begin
        cfg_regs.pairing_mode <= sfps_pkg::mode_t'(cfg.wdata[0]);
      end else if (cfg.addr == sfps_pkg::CFG_MAX_SKEW) begin
        cfg_regs.max_skew_ns <= cfg.wdata[sfps_pkg::TIME_W-1:0];
      end else if (cfg.addr == sfps_pkg::CFG_MAX_HOLD) begin
        cfg_regs.max_hold_ns <= cfg.wdata[sfps_pkg::TIME_W-1:0];
      end
    end
  end

  // handshake chain: result register frees when empty or taken,
  // input register frees when empty or moving on
  assign res_ready      = !res_valid || pair_out.ready;
  assign item_adv       = item_valid && res_ready;
  assign frame_in.ready = !item_valid || item_adv;
  assign in_xfer        = frame_in.valid && frame_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_xfer) begin
      item_valid <= 1'b1;
    end else if (item_adv) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item.left_present  <= frame_in.left_present;
      item.left_id       <= frame_in.left_id;
      item.left_time     <= frame_in.left_time;
      item.right_present <= frame_in.right_present;
      item.right_id      <= frame_in.right_id;
      item.right_time    <= frame_in.right_time;
      item.now_time      <= frame_in.now_time;
    end
  end

  // decision and held pair, loaded as the item moves to the result register
  sfps_pair_core u_core (
    .clk    (clk),
    .rst    (rst),
    .load   (item_adv),
    .cfg    (cfg_regs),
    .item   (item),
    .result (core_result),
    .status (core_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_adv) begin
      res_valid <= 1'b1;
    end else if (pair_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_adv) begin
      res <= core_result;
    end
  end

  assign pair_out.valid             = res_valid;
  assign pair_out.out_left_present  = res.left_present;
  assign pair_out.out_left_id       = res.left_id;
  assign pair_out.out_left_time     = res.left_time;
  assign pair_out.out_right_present = res.right_present;
  assign pair_out.out_right_id      = res.right_id;
  assign pair_out.out_right_time    = res.right_time;
  assign pair_out.promoted          = res.promoted;

  // once a pair is held it stays held until reset
  `SFPS_ASSERT_NEXT(a_held_sticky, clk, rst, core_status.held_valid, core_status.held_valid)
  // a promoted transfer leaves a held pair behind
  `SFPS_ASSERT_NEXT(a_promote_holds, clk, rst, item_adv && core_status.promote,
                    core_status.held_valid)
  // an item moving on always lands in the result register
  `SFPS_ASSERT_NEXT(a_item_lands, clk, rst, item_adv, res_valid)
  // a blocked item stays in the input register
  `SFPS_ASSERT_NEXT(a_item_kept, clk, rst, item_valid && !res_ready, item_valid)

endmodule
